>>> rtl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg: shared types and constants for the UTF-8 text validator
// Status codes, byte range limits, register indexes and span state.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int OUT_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH + 1 > OUT_W) ? COUNT_WIDTH + 1 : OUT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_SAT = {COUNT_WIDTH{1'b1}};

  // verdict codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_CONTROL  = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMPTY = 8'd1;
  localparam logic [15:0] MAX_SPAN_RESET = 16'd255;

  // byte range limits
  localparam logic [7:0] B_ASCII_MAX  = 8'h7f;
  localparam logic [7:0] B_LEAD2_MIN  = 8'hc2;
  localparam logic [7:0] B_LEAD2_MAX  = 8'hdf;
  localparam logic [7:0] B_LEAD3_MIN  = 8'he0;
  localparam logic [7:0] B_LEAD3_MAX  = 8'hef;
  localparam logic [7:0] B_LEAD4_MIN  = 8'hf0;
  localparam logic [7:0] B_LEAD4_MAX  = 8'hf4;
  localparam logic [7:0] B_SURR_LEAD  = 8'hed;
  localparam logic [7:0] B_E0_SEC_MIN = 8'ha0;
  localparam logic [7:0] B_ED_SEC_MAX = 8'h9f;
  localparam logic [7:0] B_F0_SEC_MIN = 8'h90;
  localparam logic [7:0] B_F4_SEC_MAX = 8'h8f;
  localparam logic [20:0] C0_END      = 21'h20;
  localparam logic [20:0] C1_FIRST    = 21'h7f;
  localparam logic [20:0] C1_LAST     = 21'h9f;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] byte_cnt;
    logic [COUNT_WIDTH-1:0] char_cnt;
    logic [1:0]             pending;
    logic [20:0]            partial;
    logic [7:0]             lead;
    logic                   second;
    logic [2:0]             err;
  } span_state_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OUT_W-1:0] total_bytes;
    logic [OUT_W-1:0] char_count;
  } result_t;

  typedef struct packed {
    logic [15:0] max_span_bytes;
    logic        allow_empty_span;
  } cfg_t;

endpackage

>>> rtl/utf8v_step.sv
// ----------------------------------------------------------------------------
// utf8v_step: next-state logic for one span byte
// Decodes one byte against the open sequence, updates counters and the
// sticky error, and forms the verdict on the last byte or an empty span.
// ----------------------------------------------------------------------------
module utf8v_step
  import utf8v_pkg::*;
(
  input  span_state_t st,
  input  cfg_t        cfg,
  input  logic [7:0]  data_byte,
  input  logic        span_last,
  input  logic        span_empty,
  output span_state_t st_next,
  output logic        res_valid,
  output result_t     res
);

  logic                   was_sat;
  logic [COUNT_WIDTH:0]   cnt_inc;
  logic                   too_long;
  logic [COUNT_WIDTH-1:0] byte_cnt_n;
  span_state_t            s;
  logic                   fin;
  logic [20:0]            fin_val;
  logic [1:0]             pend_dec;
  logic [20:0]            part_sh;
  logic                   sec_bad;

  always_comb begin
    was_sat    = (st.byte_cnt == CNT_SAT);
    cnt_inc    = {1'b0, st.byte_cnt} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    too_long   = was_sat || (CMP_W'(cnt_inc) > CMP_W'(cfg.max_span_bytes));
    byte_cnt_n = was_sat ? CNT_SAT : cnt_inc[COUNT_WIDTH-1:0];
    pend_dec   = st.pending - 2'd1;
    part_sh    = {st.partial[14:0], data_byte[5:0]};
    sec_bad    = (st.lead == B_LEAD3_MIN && data_byte < B_E0_SEC_MIN) ||
                 (st.lead == B_SURR_LEAD && data_byte > B_ED_SEC_MAX) ||
                 (st.lead == B_LEAD4_MIN && data_byte < B_F0_SEC_MIN) ||
                 (st.lead == B_LEAD4_MAX && data_byte > B_F4_SEC_MAX);

    s          = st;
    s.byte_cnt = byte_cnt_n;
    fin        = 1'b0;
    fin_val    = '0;
    if (too_long) begin
      s.err = ST_TOO_LONG;
    end

    if (s.err == ST_OK) begin
      if (st.pending == 2'd0) begin
        if (data_byte <= B_ASCII_MAX) begin
          fin     = 1'b1;
          fin_val = {13'd0, data_byte};
        end else if (data_byte >= B_LEAD2_MIN && data_byte <= B_LEAD2_MAX) begin
          s.pending = 2'd1;
          s.partial = {16'd0, data_byte[4:0]};
          s.lead    = data_byte;
          s.second  = 1'b1;
        end else if (data_byte >= B_LEAD3_MIN && data_byte <= B_LEAD3_MAX) begin
          s.pending = 2'd2;
          s.partial = {17'd0, data_byte[3:0]};
          s.lead    = data_byte;
          s.second  = 1'b1;
        end else if (data_byte >= B_LEAD4_MIN && data_byte <= B_LEAD4_MAX) begin
          s.pending = 2'd3;
          s.partial = {18'd0, data_byte[2:0]};
          s.lead    = data_byte;
          s.second  = 1'b1;
        end else begin
          s.err = ST_INVALID;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        s.err = ST_INVALID;
      end else if (st.second && sec_bad) begin
        s.err = ST_INVALID;
      end else begin
        s.second  = 1'b0;
        s.partial = part_sh;
        s.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          fin     = 1'b1;
          fin_val = part_sh;
        end
      end

      if (fin) begin
        if (fin_val < C0_END || (fin_val >= C1_FIRST && fin_val <= C1_LAST)) begin
          s.err = ST_CONTROL;
        end else if (st.char_cnt != CNT_SAT) begin
          s.char_cnt = st.char_cnt + COUNT_WIDTH'(1);
        end
      end
    end

    // sequence cut short by the end of the span
    if (span_last && s.err == ST_OK && s.pending != 2'd0) begin
      s.err = ST_INVALID;
    end

    res_valid = span_empty || span_last;
    if (span_empty) begin
      res.status      = cfg.allow_empty_span ? ST_OK : ST_EMPTY;
      res.total_bytes = '0;
      res.char_count  = '0;
    end else begin
      res.status      = s.err;
      res.total_bytes = OUT_W'(s.byte_cnt);
      res.char_count  = (s.err == ST_TOO_LONG) ? '0 : OUT_W'(s.char_cnt);
    end

    st_next = res_valid ? '0 : s;
  end

endmodule

>>> rtl/utf8_text_validator.sv
// ----------------------------------------------------------------------------
// utf8_text_validator: streaming strict UTF-8 span checker
// One verdict per text span, with byte and character counts.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a span enter on the s_ channel, one per transfer; s_tlast marks
//   the final byte and s_tuser marks a zero-length span (byte ignored, verdict
//   at once, any open span dropped). One verdict leaves on the m_ channel per
//   span: status, total byte count and valid character count.
//   The cfg channel writes max_span_bytes (index 0) and allow_empty_span
//   (index 1); it is always ready; the user must write it only while the
//   block idles, which the block itself does not enforce.
// Path: the last byte passes the input register, then the result register,
//   before m_tvalid rises and the verdict can transfer.
// Throughput: one byte per cycle while no verdict is blocked (see Stall),
//   set by the combinational step from the input register to the span state.
// Reset: rst clears the span state, drops any held byte or verdict and sets
//   max_span_bytes to 255 and allow_empty_span to 0.
// Stall: while a verdict waits on m_tready, bytes that give no verdict keep
//   flowing; a byte that would give the next verdict holds in the input
//   register and s_tready drops until the waiting verdict is taken.
// ----------------------------------------------------------------------------
module utf8_text_validator
  import utf8v_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // stream in
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 s_tlast,   // span_last
  input  logic                 s_tuser,   // span_empty
  // stream out
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // [2:0] status, [18:3] total_bytes,
                                          // [34:19] char_count, [39:35] zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        in_empty;

  // span state, configuration, result register
  span_state_t st;
  span_state_t st_next;
  cfg_t        cfg;
  logic        res_valid;
  result_t     res;
  logic        out_valid;
  result_t     out_res;

  // the held byte moves on unless it makes a verdict that has nowhere to go
  logic        adv;

  utf8v_step u_step (
    .st         (st),
    .cfg        (cfg),
    .data_byte  (in_byte),
    .span_last  (in_last),
    .span_empty (in_empty),
    .st_next    (st_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign adv       = in_valid && (!res_valid || !out_valid || m_tready);
  assign s_tready  = !in_valid || adv;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {5'd0, out_res.char_count, out_res.total_bytes, out_res.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
      cfg.max_span_bytes   <= MAX_SPAN_RESET;
      cfg.allow_empty_span <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv) begin
        st <= st_next;
      end
      if (adv && res_valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_SPAN:    cfg.max_span_bytes   <= cfg_data;
          REG_ALLOW_EMPTY: cfg.allow_empty_span <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_last  <= s_tlast;
      in_empty <= s_tuser;
    end
    if (adv && res_valid) begin
      out_res <= res;
    end
  end

  // a too-long verdict never reports characters
  a_too_long_no_chars: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == ST_TOO_LONG |-> out_res.char_count == '0)
    else $error("too-long verdict with nonzero char count");

  // an empty verdict carries no counts
  a_empty_no_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == ST_EMPTY |->
      out_res.total_bytes == '0 && out_res.char_count == '0)
    else $error("empty verdict with nonzero counts");

  // an open sequence always has a valid lead byte recorded
  a_open_seq_lead: assert property (@(posedge clk) disable iff (rst)
    st.err == ST_OK && st.pending != 2'd0 |-> st.lead >= B_LEAD2_MIN)
    else $error("pending continuation bytes without a lead byte");

  // a stalled input side means a verdict is blocked by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && res_valid && out_valid && !m_tready)
    else $error("input stalled without a blocked verdict");

  // characters never outnumber bytes within a span
  a_chars_le_bytes: assert property (@(posedge clk) disable iff (rst)
    st.char_cnt <= st.byte_cnt)
    else $error("character count exceeds byte count");

endmodule

>>> bench/utf8_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_span_checker: verdict predictor and scoreboard for the span validator
// Follows config writes and byte transfers, predicts each span verdict and
// compares every verdict transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_span_checker
  import utf8v_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic                 s_tlast,
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [39:0]          m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   verdicts_due
);

  localparam logic [2:0] NO_ERROR   = ST_OK;

  // shadow configuration
  logic [15:0] limit_bytes;
  logic        empty_ok;

  // shadow span state
  logic [15:0] n_bytes;
  logic [15:0] n_chars;
  logic [1:0]  cont_left;
  logic [20:0] scalar_acc;
  logic [7:0]  seq_lead;
  logic        at_second;
  logic [2:0]  first_err;

  result_t verdict_q[$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns checker: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_span();
    n_bytes    = '0;
    n_chars    = '0;
    cont_left  = '0;
    scalar_acc = '0;
    seq_lead   = '0;
    at_second  = 1'b0;
    first_err  = NO_ERROR;
  endtask

  function automatic logic is_control_scalar(input logic [20:0] s);
    return (s < C0_END) || (s >= C1_FIRST && s <= C1_LAST);
  endfunction

  task automatic end_scalar(input logic [20:0] s);
    if (is_control_scalar(s))
      first_err = ST_CONTROL;
    else if (n_chars != CNT_SAT)
      n_chars = n_chars + 16'd1;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (cont_left == 2'd0) begin
      if (b <= B_ASCII_MAX) begin
        end_scalar({13'd0, b});
      end else if (b >= B_LEAD2_MIN && b <= B_LEAD2_MAX) begin
        cont_left  = 2'd1;
        scalar_acc = {16'd0, b[4:0]};
        seq_lead   = b;
        at_second  = 1'b1;
      end else if (b >= B_LEAD3_MIN && b <= B_LEAD3_MAX) begin
        cont_left  = 2'd2;
        scalar_acc = {17'd0, b[3:0]};
        seq_lead   = b;
        at_second  = 1'b1;
      end else if (b >= B_LEAD4_MIN && b <= B_LEAD4_MAX) begin
        cont_left  = 2'd3;
        scalar_acc = {18'd0, b[2:0]};
        seq_lead   = b;
        at_second  = 1'b1;
      end else begin
        first_err = ST_INVALID;
      end
    end else if (b[7:6] != 2'b10) begin
      first_err = ST_INVALID;
    end else if (at_second &&
                 ((seq_lead == B_LEAD3_MIN && b < B_E0_SEC_MIN) ||
                  (seq_lead == B_SURR_LEAD && b > B_ED_SEC_MAX) ||
                  (seq_lead == B_LEAD4_MIN && b < B_F0_SEC_MIN) ||
                  (seq_lead == B_LEAD4_MAX && b > B_F4_SEC_MAX))) begin
      // overlong, surrogate or beyond U+10FFFF
      first_err = ST_INVALID;
    end else begin
      at_second  = 1'b0;
      scalar_acc = {scalar_acc[14:0], b[5:0]};
      cont_left  = cont_left - 2'd1;
      if (cont_left == 2'd0)
        end_scalar(scalar_acc);
    end
  endtask

  task automatic predict_transfer(input logic [7:0] b, input logic last, input logic empty);
    result_t    r;
    logic [16:0] next_cnt;
    if (empty) begin
      // drops any open span, outranks tlast
      clear_span();
      r.status      = empty_ok ? ST_OK : ST_EMPTY;
      r.total_bytes = '0;
      r.char_count  = '0;
      verdict_q.push_back(r);
    end else begin
      next_cnt = {1'b0, n_bytes} + 17'd1;
      if (n_bytes == CNT_SAT || next_cnt > {1'b0, limit_bytes})
        first_err = ST_TOO_LONG;
      if (n_bytes != CNT_SAT)
        n_bytes = next_cnt[15:0];
      if (first_err == NO_ERROR)
        decode_byte(b);
      if (last) begin
        if (first_err == NO_ERROR && cont_left != 2'd0)
          first_err = ST_INVALID;
        r.status      = first_err;
        r.total_bytes = n_bytes;
        r.char_count  = (first_err == ST_TOO_LONG) ? 16'd0 : n_chars;
        verdict_q.push_back(r);
        clear_span();
      end
    end
  endtask

  task automatic check_verdict(input logic [39:0] word);
    result_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch("verdict with none pending, status", int'(word[2:0]), -1);
    end else begin
      want = verdict_q.pop_front();
      if (word[2:0] !== want.status)
        report_mismatch("status", int'(word[2:0]), int'(want.status));
      if (word[18:3] !== want.total_bytes)
        report_mismatch("total_bytes", int'(word[18:3]), int'(want.total_bytes));
      if (word[34:19] !== want.char_count)
        report_mismatch("char_count", int'(word[34:19]), int'(want.char_count));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit_bytes = MAX_SPAN_RESET;
      empty_ok    = 1'b0;
      clear_span();
      verdict_q.delete();
    end else begin
      // compare before predicting: a verdict never leaves in its own byte's cycle
      if (m_tvalid && m_tready)
        check_verdict(m_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_SPAN)
          limit_bytes = cfg_data;
        else if (cfg_index == REG_ALLOW_EMPTY)
          empty_ok = cfg_data[0];
      end
      if (s_tvalid && s_tready)
        predict_transfer(s_tdata, s_tlast, s_tuser);
    end
    verdicts_due <= verdict_q.size();
  end

endmodule

>>> bench/tb_utf8_text_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_text_validator: stimulus and verdict for the UTF-8 span validator
// Drives directed spans for every status and decoder corner, then random
// well-formed, broken and noise spans under several register settings, with
// random idling on both streams, a long receiver hold-off and a sender pause
// until every verdict is back. The checker predicts and scores every verdict.
// ----------------------------------------------------------------------------
module tb_utf8_text_validator;
  import utf8v_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int IDLE_PCT        = 27;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int RANDOM_ITEMS    = 400;
  localparam int RANDOM_PHASES   = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = REG_ALLOW_EMPTY + 1'b1;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 s_tuser   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [39:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  int fail_count;
  int verdicts_due;

  bit         steady      = 1'b0;   // no idling on either stream while set
  int         hold_off    = 0;      // receiver stall cycles still to run
  int         items_sent  = 0;
  int         cycle_count = 0;
  logic [7:0] span_buf[$];

  always #2 clk = ~clk;

  utf8_text_validator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  utf8_span_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .verdicts_due (verdicts_due)
  );

  // Verdict receiver: random back-pressure, or a counted hold-off when asked.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off = hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Run guard: ends a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[utf8_text_validator] ERROR");
    $finish;
  end

  // One byte transfer, after a random number of idle cycles.
  // Exactly one assignment per signal per edge, so back-to-back items keep
  // tvalid high without a glitch.
  task automatic offer(input logic [7:0] b, input logic last, input logic empty);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(255));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= empty;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Up to four bytes from the low n bytes of w, first byte the most significant.
  task automatic send_bytes(input int n, input logic [31:0] w, input logic last);
    for (int k = n - 1; k >= 0; k--)
      offer(w[8*k +: 8], last && (k == 0), 1'b0);
  endtask

  task automatic send_buf(input logic close);
    foreach (span_buf[k])
      offer(span_buf[k], close && (k == span_buf.size() - 1), 1'b0);
  endtask

  // Quiet the input and wait for every pending verdict. The checker count
  // is registered, so the loop waits on an edge before each look.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers plus one write to an unmapped index (must be
  // ignored). Only called while the block is idle.
  task automatic configure(input logic [15:0] max_bytes, input logic empty_is_ok);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [15:0]          val [3];
    idx[0] = REG_MAX_SPAN;
    val[0] = max_bytes;
    idx[1] = REG_ALLOW_EMPTY;
    val[1] = {15'($urandom), empty_is_ok};
    idx[2] = CFG_IDX_W'($urandom_range(int'(FIRST_UNUSED_REG), (1 << CFG_IDX_W) - 1));
    val[2] = 16'($urandom);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random scalar, weighted toward printable text with every encoded length,
  // range edges and now and then a control character.
  function automatic logic [20:0] pick_scalar();
    logic [20:0] edges [10];
    logic [20:0] s;
    edges = '{21'h20, 21'h7e, 21'ha0, 21'h7ff, 21'h800,
              21'hd7ff, 21'he000, 21'hffff, 21'h10000, 21'h10ffff};
    case ($urandom_range(15))
      6, 7:    s = 21'($urandom_range(21'h7ff, 21'ha0));
      8, 9: begin
        s = 21'($urandom_range(21'hffff, 21'h800));
        if (s >= 21'hd800 && s <= 21'hdfff)
          s = s ^ 21'h4000;              // steer off the surrogate block
      end
      10, 11:  s = 21'($urandom_range(21'h10ffff, 21'h10000));
      12, 13:  s = edges[$urandom_range(9)];
      14:      s = $urandom_range(1) ? 21'($urandom_range(21'h1f, 0))
                                     : 21'($urandom_range(21'h9f, 21'h7f));
      default: s = 21'($urandom_range(21'h7e, 21'h20));
    endcase
    return s;
  endfunction

  task automatic encode_scalar(input logic [20:0] s);
    if (s < 21'h80) begin
      span_buf.push_back(s[7:0]);
    end else if (s < 21'h800) begin
      span_buf.push_back({3'b110, s[10:6]});
      span_buf.push_back({2'b10, s[5:0]});
    end else if (s < 21'h10000) begin
      span_buf.push_back({4'b1110, s[15:12]});
      span_buf.push_back({2'b10, s[11:6]});
      span_buf.push_back({2'b10, s[5:0]});
    end else begin
      span_buf.push_back({5'b11110, s[20:18]});
      span_buf.push_back({2'b10, s[17:12]});
      span_buf.push_back({2'b10, s[11:6]});
      span_buf.push_back({2'b10, s[5:0]});
    end
  endtask

  // Mostly well-formed spans with random content; the rest are corrupted,
  // truncated, abandoned by an empty marker, raw noise or empty spans.
  task automatic random_span();
    int kind;
    int nchars;
    int pos;
    span_buf.delete();
    kind = $urandom_range(19);
    if (kind == 0) begin
      // empty span; tlast is random since the empty marker wins
      offer(8'($urandom), 1'($urandom), 1'b1);
    end else if (kind == 1) begin
      repeat ($urandom_range(6, 1)) span_buf.push_back(8'($urandom));
      send_buf(1'b1);
    end else begin
      nchars = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      repeat (nchars) encode_scalar(pick_scalar());
      if (kind == 2) begin
        pos = $urandom_range(span_buf.size() - 1);
        span_buf[pos] = 8'($urandom);
      end else if (kind == 3 && span_buf.size() > 1) begin
        void'(span_buf.pop_back());
      end
      if (kind == 4) begin
        send_buf(1'b0);
        offer(8'($urandom), 1'($urandom), 1'b1);
      end else begin
        send_buf(1'b1);
      end
    end
  endtask

  initial begin
    int  phase_start;
    bit  paused;
    logic [15:0] phase_max;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset settings (limit 255, empty not ok) ---
    offer(8'hff, 1'b0, 1'b1);              // empty span
    send_bytes(1, 32'h41, 1'b1);           // plain ASCII
    send_bytes(1, 32'h00, 1'b1);           // C0 control, lowest byte
    send_bytes(1, 32'h7f, 1'b1);           // DEL
    send_bytes(2, 32'hc280, 1'b1);         // U+0080, C1 control
    send_bytes(2, 32'hc2a0, 1'b1);         // first non-control two-byte scalar
    send_bytes(2, 32'he080, 1'b1);         // overlong three-byte form
    send_bytes(2, 32'heda0, 1'b1);         // surrogate
    send_bytes(2, 32'hf490, 1'b1);         // above U+10FFFF
    send_bytes(4, 32'hf09f9880, 1'b1);     // valid four-byte scalar
    send_bytes(1, 32'hff, 1'b1);           // never a lead byte
    send_bytes(2, 32'he282, 1'b1);         // sequence cut short by the end
    send_bytes(1, 32'hc3, 1'b0);           // open sequence ...
    offer(8'h41, 1'b1, 1'b1);              // ... dropped by an empty marker
    settle();

    // limit of one byte, empty spans ok
    configure(16'd1, 1'b1);
    offer(8'h00, 1'b0, 1'b1);
    send_bytes(1, 32'h7a, 1'b1);
    send_bytes(2, 32'h4142, 1'b1);         // too long
    send_bytes(2, 32'hc2a0, 1'b1);         // too long outranks the open sequence
    settle();

    // zero limit: every non-empty span is too long
    configure(16'd0, 1'b0);
    send_bytes(1, 32'h41, 1'b1);
    offer(8'h00, 1'b1, 1'b1);
    settle();

    // --- random spans over several settings ---
    paused = 1'b0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       phase_max = 16'($urandom_range(32, 1));
        1:       phase_max = 16'hffff;
        2:       phase_max = 16'($urandom_range(8, 1));
        default: phase_max = 16'($urandom_range(24, 4));
      endcase
      configure(phase_max, 1'($urandom));
      steady = (phase == 1);               // a long stretch with no idling
      if (phase == 2)
        hold_off = HOLD_OFF_CYCLES;        // verdicts back up, input must stall
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
        random_span();
        if (phase == 3 && !paused &&
            items_sent - phase_start >= RANDOM_ITEMS / (2 * RANDOM_PHASES)) begin
          settle();                        // sender waits for every verdict
          paused = 1'b1;
        end
      end
      settle();
      steady = 1'b0;
    end

    if (fail_count == 0) begin
      $display("[utf8_text_validator] OK");
    end else begin
      $display("[utf8_text_validator] ERROR");
    end
    $finish;
  end

endmodule
